// File: rtl/box_non_max_suppression_macros.svh
// ----------------------------------------------------------------------------
// Box NMS assertion macros
// Shared assertion wrappers for the box non-maximum suppression checker.
// ----------------------------------------------------------------------------
`ifndef BOX_NON_MAX_SUPPRESSION_MACROS_SVH
`define BOX_NON_MAX_SUPPRESSION_MACROS_SVH

// Assertion sampled on clk and disabled while reset is asserted.
`define NMS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on clk that also holds during reset.
`define NMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nms_pkg.sv
// ----------------------------------------------------------------------------
// NMS package
// Sizes, register codes and record types shared by the NMS modules.
// ----------------------------------------------------------------------------
package nms_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int SCORE_W    = 16;
    localparam int LIMIT_W    = 16;
    localparam int OUT_W      = 12;
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = AREA_W + MUL_B_W;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register index codes, taken from paddr[2].
    localparam logic REG_OVERLAP = 1'b0;
    localparam logic REG_SCORE   = 1'b1;

    localparam logic [LIMIT_W-1:0] OVERLAP_RESET = 16'd45875;
    localparam logic [LIMIT_W-1:0] SCORE_RESET   = 16'd32768;

    typedef struct packed {
        logic [SCORE_W-1:0]    score;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] x0;
    } box_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } rank_t;

    localparam int BOX_W  = $bits(box_t);
    localparam int RANK_W = $bits(rank_t);

endpackage

// File: rtl/box_non_max_suppression.sv
// ----------------------------------------------------------------------------
// Box non-maximum suppression
// Collects a batch of detection boxes, ranks them by score and drops boxes
// that overlap a higher-ranked survivor too much.
// ----------------------------------------------------------------------------
// A word is accepted at each rising edge with start high and busy low; each
// result word is shown for exactly one cycle with result_valid high and the
// receiver cannot stall it. Loading a box stores it, then forms its area
// product on the shared multiplier; busy holds off the next word meanwhile.
// The word that carries last_box starts the batch work: an exchange sort
// over box pairs, then suppression that runs each pair as far as needed
// through rank read, box read, geometry, two products on the one shared
// multiplier and a compare, then an output scan over the stored boxes. The
// shared multiplier and the single read port of each RAM set the pace of
// all of this batch work. busy drops in the cycle that shows
// the last result word of the batch. Results come in input order; the
// final one carries last_out, and a batch with no survivor yields a single
// word with none_kept and last_out set and all other fields zero. A batch of
// one box is passed through without the score test. Boxes beyond the store
// capacity are dropped, though last_box on such a box still ends the batch.
// ----------------------------------------------------------------------------
module box_non_max_suppression (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [11:0]                   x_min,
    input  logic [11:0]                   x_max,
    input  logic [11:0]                   y_min,
    input  logic [11:0]                   y_max,
    input  logic [15:0]                   score,
    input  logic                          last_box,
    output logic                          result_valid,
    output logic [11:0]                   out_x_min,
    output logic [11:0]                   out_x_max,
    output logic [11:0]                   out_y_min,
    output logic [11:0]                   out_y_max,
    output logic [15:0]                   out_score,
    output logic                          last_out,
    output logic                          none_kept,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nms_pkg::ADDR_W-1:0]    paddr,
    input  logic [nms_pkg::DATA_W-1:0]    pwdata,
    output logic [nms_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    import nms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AREA,
        S_AREA_WR,
        S_BEGIN,
        S_ONE_RD,
        S_ONE_OUT,
        S_SORT_RI,
        S_SORT_LI,
        S_SORT_RJ,
        S_SORT_CJ,
        S_SUP_RI,
        S_SUP_LI,
        S_SUP_LA,
        S_SUP_RJ,
        S_SUP_LJ,
        S_SUP_GEO,
        S_SUP_M1,
        S_SUP_M2,
        S_SUP_CMP,
        S_OUT_RK,
        S_OUT_CK
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic                    last_reg, last_next;
    logic [COORD_BITS-1:0]   span_x_reg, span_x_next;
    logic [COORD_BITS-1:0]   span_y_reg, span_y_next;
    rank_t                   cur_reg, cur_next;
    box_t                    a_box_reg, a_box_next;
    logic [IDX_W-1:0]        b_idx_reg, b_idx_next;
    logic [COORD_BITS-1:0]   w_reg, w_next;
    logic [COORD_BITS-1:0]   h_reg, h_next;
    logic [AREA_W-1:0]       area_reg, area_next;
    logic [AREA_W-1:0]       ov_reg, ov_next;
    logic [MAX_BOXES-1:0]    supp_reg, supp_next;
    box_t                    pend_reg, pend_next;
    logic                    have_pend_reg, have_pend_next;
    logic                    rv_reg, rv_next;
    box_t                    o_box_reg, o_box_next;
    logic                    o_last_reg, o_last_next;
    logic                    o_none_reg, o_none_next;
    logic [LIMIT_W-1:0]      overlap_reg, overlap_next;
    logic [LIMIT_W-1:0]      score_lim_reg, score_lim_next;

    // RAM and multiplier hookup.
    logic                    box_we;
    logic [IDX_W-1:0]        box_waddr;
    box_t                    box_wdata;
    logic [IDX_W-1:0]        box_raddr;
    box_t                    box_rdata;
    logic                    area_we;
    logic [AREA_W-1:0]       area_wdata;
    logic [AREA_W-1:0]       area_rdata;
    logic                    rank_we;
    logic [IDX_W-1:0]        rank_waddr;
    rank_t                   rank_wdata;
    logic [IDX_W-1:0]        rank_raddr;
    rank_t                   rank_rdata;
    logic [AREA_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       mul_p;

    // Incoming box, cut to the coordinate width, and its side lengths.
    box_t                    in_box;
    logic [COORD_BITS-1:0]   in_span_x;
    logic [COORD_BITS-1:0]   in_span_y;
    logic                    accept;
    logic                    cfg_wr;

    // Intersection of the held box with the box just read.
    logic [COORD_BITS-1:0]   ov_l, ov_r, ov_lo, ov_hi;
    logic [CNT_W-1:0]        i_inc;
    logic                    i_done;

    nms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (box_waddr),
        .wdata (box_wdata),
        .raddr (box_raddr),
        .rdata (box_rdata)
    );

    // The area store is written at the same slot as the box store and read
    // alongside it, so it shares the box addresses.
    nms_ram #(.WIDTH(AREA_W), .DEPTH(MAX_BOXES)) u_area_ram (
        .clk   (clk),
        .we    (area_we),
        .waddr (box_waddr),
        .wdata (area_wdata),
        .raddr (box_raddr),
        .rdata (area_rdata)
    );

    // Each rank entry carries its store index and a copy of the score, so
    // the sort needs one read per comparison.
    nms_ram #(.WIDTH(RANK_W), .DEPTH(MAX_BOXES)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    nms_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_OVERLAP: prdata = {{(DATA_W - LIMIT_W){1'b0}}, overlap_reg};
            REG_SCORE:   prdata = {{(DATA_W - LIMIT_W){1'b0}}, score_lim_reg};
            default:     prdata = '0;
        endcase
    end

    assign in_box.x0    = COORD_BITS'(x_min);
    assign in_box.x1    = COORD_BITS'(x_max);
    assign in_box.y0    = COORD_BITS'(y_min);
    assign in_box.y1    = COORD_BITS'(y_max);
    assign in_box.score = score;
    assign in_span_x    = (in_box.x1 > in_box.x0) ? (in_box.x1 - in_box.x0) : '0;
    assign in_span_y    = (in_box.y1 > in_box.y0) ? (in_box.y1 - in_box.y0) : '0;

    assign ov_l  = (a_box_reg.x0 > box_rdata.x0) ? a_box_reg.x0 : box_rdata.x0;
    assign ov_r  = (a_box_reg.x1 < box_rdata.x1) ? a_box_reg.x1 : box_rdata.x1;
    assign ov_lo = (a_box_reg.y0 > box_rdata.y0) ? a_box_reg.y0 : box_rdata.y0;
    assign ov_hi = (a_box_reg.y1 < box_rdata.y1) ? a_box_reg.y1 : box_rdata.y1;

    // The outer loops stop once only the lowest-ranked entry is left.
    assign i_inc  = i_reg + CNT_W'(1);
    assign i_done = (i_inc == (n_reg - CNT_W'(1)));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        cur_next       = cur_reg;
        a_box_next     = a_box_reg;
        b_idx_next     = b_idx_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        area_next      = area_reg;
        ov_next        = ov_reg;
        supp_next      = supp_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        rv_next        = 1'b0;
        o_box_next     = o_box_reg;
        o_last_next    = o_last_reg;
        o_none_next    = o_none_reg;
        overlap_next   = overlap_reg;
        score_lim_next = score_lim_reg;

        box_we     = 1'b0;
        box_waddr  = cnt_reg[IDX_W-1:0];
        box_wdata  = in_box;
        box_raddr  = i_reg[IDX_W-1:0];
        area_we    = 1'b0;
        area_wdata = mul_p[AREA_W-1:0];
        rank_we    = 1'b0;
        rank_waddr = cnt_reg[IDX_W-1:0];
        rank_wdata = '{idx: cnt_reg[IDX_W-1:0], score: in_box.score};
        rank_raddr = i_reg[IDX_W-1:0];
        mul_a      = AREA_W'(span_x_reg);
        mul_b      = MUL_B_W'(span_y_reg);

        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_OVERLAP: overlap_next   = pwdata[LIMIT_W-1:0];
                REG_SCORE:   score_lim_next = pwdata[LIMIT_W-1:0];
                default:     ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next   = last_box;
                    span_x_next = in_span_x;
                    span_y_next = in_span_y;
                    if (cnt_reg < CNT_W'(MAX_BOXES))
                    begin
                        box_we     = 1'b1;
                        rank_we    = 1'b1;
                        state_next = S_AREA;
                    end
                    else if (last_box)
                    begin
                        state_next = S_BEGIN;
                    end
                end
            end

            S_AREA:
            begin
                state_next = S_AREA_WR;
            end

            S_AREA_WR:
            begin
                area_we    = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = last_reg ? S_BEGIN : S_IDLE;
            end

            S_BEGIN:
            begin
                n_next    = cnt_reg;
                cnt_next  = '0;
                supp_next = '0;
                i_next    = '0;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_ONE_RD;
                end
                else
                begin
                    state_next = S_SORT_RI;
                end
            end

            S_ONE_RD:
            begin
                box_raddr  = '0;
                state_next = S_ONE_OUT;
            end

            S_ONE_OUT:
            begin
                rv_next     = 1'b1;
                o_box_next  = box_rdata;
                o_last_next = 1'b1;
                o_none_next = 1'b0;
                state_next  = S_IDLE;
            end

            S_SORT_RI:
            begin
                rank_raddr = i_reg[IDX_W-1:0];
                j_next     = i_inc;
                state_next = S_SORT_LI;
            end

            S_SORT_LI:
            begin
                cur_next   = rank_rdata;
                state_next = S_SORT_RJ;
            end

            S_SORT_RJ:
            begin
                if (j_reg == n_reg)
                begin
                    // Inner pass done: the held entry belongs at rank i.
                    rank_we    = 1'b1;
                    rank_waddr = i_reg[IDX_W-1:0];
                    rank_wdata = cur_reg;
                    if (i_done)
                    begin
                        i_next     = '0;
                        state_next = S_SUP_RI;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_SORT_RI;
                    end
                end
                else
                begin
                    rank_raddr = j_reg[IDX_W-1:0];
                    state_next = S_SORT_CJ;
                end
            end

            S_SORT_CJ:
            begin
                if (rank_rdata.score > cur_reg.score)
                begin
                    rank_we    = 1'b1;
                    rank_waddr = j_reg[IDX_W-1:0];
                    rank_wdata = cur_reg;
                    cur_next   = rank_rdata;
                end
                j_next     = j_reg + CNT_W'(1);
                state_next = S_SORT_RJ;
            end

            S_SUP_RI:
            begin
                rank_raddr = i_reg[IDX_W-1:0];
                state_next = S_SUP_LI;
            end

            S_SUP_LI:
            begin
                box_raddr = rank_rdata.idx;
                if (supp_reg[rank_rdata.idx])
                begin
                    i_next = i_done ? '0 : i_inc;
                    if (i_done)
                    begin
                        have_pend_next = 1'b0;
                        state_next     = S_OUT_RK;
                    end
                    else
                    begin
                        state_next = S_SUP_RI;
                    end
                end
                else
                begin
                    state_next = S_SUP_LA;
                end
            end

            S_SUP_LA:
            begin
                a_box_next = box_rdata;
                j_next     = i_inc;
                state_next = S_SUP_RJ;
            end

            S_SUP_RJ:
            begin
                if (j_reg == n_reg)
                begin
                    i_next = i_done ? '0 : i_inc;
                    if (i_done)
                    begin
                        have_pend_next = 1'b0;
                        state_next     = S_OUT_RK;
                    end
                    else
                    begin
                        state_next = S_SUP_RI;
                    end
                end
                else
                begin
                    rank_raddr = j_reg[IDX_W-1:0];
                    state_next = S_SUP_LJ;
                end
            end

            S_SUP_LJ:
            begin
                b_idx_next = rank_rdata.idx;
                box_raddr  = rank_rdata.idx;
                if (supp_reg[rank_rdata.idx])
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_SUP_RJ;
                end
                else
                begin
                    state_next = S_SUP_GEO;
                end
            end

            S_SUP_GEO:
            begin
                w_next    = ov_r - ov_l;
                h_next    = ov_hi - ov_lo;
                area_next = area_rdata;
                if ((ov_r <= ov_l) || (ov_hi <= ov_lo))
                begin
                    // No positive overlap, so nothing to test.
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_SUP_RJ;
                end
                else
                begin
                    state_next = S_SUP_M1;
                end
            end

            S_SUP_M1:
            begin
                mul_a      = AREA_W'(w_reg);
                mul_b      = MUL_B_W'(h_reg);
                state_next = S_SUP_M2;
            end

            S_SUP_M2:
            begin
                ov_next    = mul_p[AREA_W-1:0];
                mul_a      = area_reg;
                mul_b      = MUL_B_W'(overlap_reg);
                state_next = S_SUP_CMP;
            end

            S_SUP_CMP:
            begin
                // overlap * 2^16 against limit * area of the lower-ranked box.
                if ({ov_reg, {MUL_B_W{1'b0}}} > mul_p)
                begin
                    supp_next[b_idx_reg] = 1'b1;
                end
                j_next     = j_reg + CNT_W'(1);
                state_next = S_SUP_RJ;
            end

            S_OUT_RK:
            begin
                if (i_reg == n_reg)
                begin
                    rv_next     = 1'b1;
                    o_last_next = 1'b1;
                    if (have_pend_reg)
                    begin
                        o_box_next  = pend_reg;
                        o_none_next = 1'b0;
                    end
                    else
                    begin
                        o_box_next  = '0;
                        o_none_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    box_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_OUT_CK;
                end
            end

            S_OUT_CK:
            begin
                // One survivor is held back so the final one can carry
                // last_out.
                if (!supp_reg[i_reg[IDX_W-1:0]] && (box_rdata.score > score_lim_reg))
                begin
                    if (have_pend_reg)
                    begin
                        rv_next     = 1'b1;
                        o_box_next  = pend_reg;
                        o_last_next = 1'b0;
                        o_none_next = 1'b0;
                    end
                    pend_next      = box_rdata;
                    have_pend_next = 1'b1;
                end
                i_next     = i_inc;
                state_next = S_OUT_RK;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            last_reg      <= 1'b0;
            supp_reg      <= '0;
            have_pend_reg <= 1'b0;
            rv_reg        <= 1'b0;
            o_last_reg    <= 1'b0;
            o_none_reg    <= 1'b0;
            overlap_reg   <= OVERLAP_RESET;
            score_lim_reg <= SCORE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            last_reg      <= last_next;
            supp_reg      <= supp_next;
            have_pend_reg <= have_pend_next;
            rv_reg        <= rv_next;
            o_last_reg    <= o_last_next;
            o_none_reg    <= o_none_next;
            overlap_reg   <= overlap_next;
            score_lim_reg <= score_lim_next;
        end
    end

    // Data path registers carry no reset.
    always_ff @(posedge clk)
    begin
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        cur_reg    <= cur_next;
        a_box_reg  <= a_box_next;
        b_idx_reg  <= b_idx_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        area_reg   <= area_next;
        ov_reg     <= ov_next;
        pend_reg   <= pend_next;
        o_box_reg  <= o_box_next;
    end

    assign result_valid = rv_reg;
    assign out_x_min    = OUT_W'(o_box_reg.x0);
    assign out_x_max    = OUT_W'(o_box_reg.x1);
    assign out_y_min    = OUT_W'(o_box_reg.y0);
    assign out_y_max    = OUT_W'(o_box_reg.y1);
    assign out_score    = o_box_reg.score;
    assign last_out     = o_last_reg;
    assign none_kept    = o_none_reg;

endmodule

// File: rtl/nms_ram.sv
// ----------------------------------------------------------------------------
// NMS RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nms_mul.sv
// ----------------------------------------------------------------------------
// NMS multiplier
// Shared registered multiplier for box areas, overlaps and limit products.
// ----------------------------------------------------------------------------
module nms_mul (
    input  logic                        clk,
    input  logic [nms_pkg::AREA_W-1:0]  a,
    input  logic [nms_pkg::MUL_B_W-1:0] b,
    output logic [nms_pkg::PROD_W-1:0]  p
);

    import nms_pkg::*;

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// File: rtl/nms_checker.sv
// ----------------------------------------------------------------------------
// NMS checker
// Port-level assertions for the box non-maximum suppression block.
// ----------------------------------------------------------------------------
`include "box_non_max_suppression_macros.svh"

module nms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last_box,
    input logic        result_valid,
    input logic        last_out,
    input logic        none_kept,
    input logic [11:0] out_x_min,
    input logic [15:0] out_score
);

    logic none_ok;

    assign none_ok = last_out && (out_x_min == 12'd0) && (out_score == 16'd0);

    // The word that closes a batch is followed by a quiet cycle.
    `NMS_ASSERT_RST(a_gap, (result_valid && last_out) |=> !result_valid, "word after batch end")

    // A none_kept word must be final, with zero x_min and zero score.
    `NMS_ASSERT_RST(a_none, (result_valid && none_kept) |-> none_ok, "bad none_kept word")

    // A word that ends a batch always starts batch processing.
    `NMS_ASSERT_RST(a_batch, (start && !busy && last_box) |=> busy, "batch end not taken")

    // Only the final word of a batch may coincide with the block going idle.
    `NMS_ASSERT_ALWAYS(a_mid, (result_valid && !last_out) |-> busy, "idle during a batch")

endmodule

bind box_non_max_suppression nms_checker u_nms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_box     (last_box),
    .result_valid (result_valid),
    .last_out     (last_out),
    .none_kept    (none_kept),
    .out_x_min    (out_x_min),
    .out_score    (out_score)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Box NMS testbench
// Drives batches of detection boxes through the suppression block, programs the
// overlap and score limits over the register port between phases, predicts the
// kept boxes of each batch in software and compares every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import nms_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    // One box as it is offered to the block.
    typedef struct {
        logic [11:0] x0;
        logic [11:0] x1;
        logic [11:0] y0;
        logic [11:0] y1;
        logic [15:0] sc;
        logic        last;
    } box_word_t;

    // One result word as the block should show it.
    typedef struct {
        logic [11:0] x0;
        logic [11:0] x1;
        logic [11:0] y0;
        logic [11:0] y1;
        logic [15:0] sc;
        logic        last;
        logic        none;
    } kept_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [11:0] x_min, x_max, y_min, y_max;
    logic [15:0] score;
    logic        last_box;
    logic        result_valid;
    logic [11:0] out_x_min, out_x_max, out_y_min, out_y_max;
    logic [15:0] out_score;
    logic        last_out;
    logic        none_kept;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    box_non_max_suppression u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_min(x_min), .x_max(x_max), .y_min(y_min), .y_max(y_max),
        .score(score), .last_box(last_box),
        .result_valid(result_valid),
        .out_x_min(out_x_min), .out_x_max(out_x_max),
        .out_y_min(out_y_min), .out_y_max(out_y_max),
        .out_score(out_score), .last_out(last_out), .none_kept(none_kept),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predictor state: its own copy of the limits and the current batch.
    logic [15:0] overlap_lim;
    logic [15:0] score_lim;
    box_word_t   batch_boxes[$];
    kept_word_t  expected_kept[$];

    // Boxes waiting for the driver; the initial block fills this queue.
    box_word_t   pending_boxes[$];
    logic        drive_on;     // the driver may offer boxes
    logic        quiet_tail;   // no random gaps in the last part
    int          gap_left;
    int          error_count;
    int          cycle_count;

    function automatic logic [23:0] rect_size(box_word_t b);
        logic [11:0] w, h;
        w = (b.x1 > b.x0) ? b.x1 - b.x0 : 12'd0;
        h = (b.y1 > b.y0) ? b.y1 - b.y0 : 12'd0;
        return 24'(w) * 24'(h);
    endfunction

    function automatic kept_word_t as_kept(box_word_t b, logic last);
        kept_word_t k;
        k.x0 = b.x0; k.x1 = b.x1; k.y0 = b.y0; k.y1 = b.y1;
        k.sc = b.sc; k.last = last; k.none = 1'b0;
        return k;
    endfunction

    // Runs the whole batch: rank by score, suppress by overlap, then emit the
    // survivors above the score limit in arrival order, or a none_kept word; a lone box is always kept.
    task automatic predict_batch();
        int          n, cnt;
        int          rank[$];
        bit          gone[$];
        int          t;
        logic [11:0] l, r, lo, hi;
        logic [63:0] ov, rhs;
        kept_word_t  k;
        n = batch_boxes.size();
        if (n == 1) begin
            expected_kept = {expected_kept, as_kept(batch_boxes[0], 1'b1)};
            batch_boxes.delete();
            return;
        end
        for (int i = 0; i < n; i++) begin
            rank = {rank, i};
            gone = {gone, 1'b0};
        end
        // Exchange sort, swapping only on a strictly higher score.
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (batch_boxes[rank[j]].sc > batch_boxes[rank[i]].sc) begin
                    t = rank[i]; rank[i] = rank[j]; rank[j] = t;
                end
        for (int i = 0; i + 1 < n; i++) begin
            if (gone[rank[i]]) continue;
            for (int j = i + 1; j < n; j++) begin
                if (gone[rank[j]]) continue;
                l  = (batch_boxes[rank[i]].x0 > batch_boxes[rank[j]].x0) ?
                     batch_boxes[rank[i]].x0 : batch_boxes[rank[j]].x0;
                r  = (batch_boxes[rank[i]].x1 < batch_boxes[rank[j]].x1) ?
                     batch_boxes[rank[i]].x1 : batch_boxes[rank[j]].x1;
                lo = (batch_boxes[rank[i]].y0 > batch_boxes[rank[j]].y0) ?
                     batch_boxes[rank[i]].y0 : batch_boxes[rank[j]].y0;
                hi = (batch_boxes[rank[i]].y1 < batch_boxes[rank[j]].y1) ?
                     batch_boxes[rank[i]].y1 : batch_boxes[rank[j]].y1;
                if (r <= l || hi <= lo) continue;
                ov  = 64'(r - l) * 64'(hi - lo);
                rhs = 64'(overlap_lim) * 64'(rect_size(batch_boxes[rank[j]]));
                if ((ov << 16) > rhs) gone[rank[j]] = 1'b1;
            end
        end
        cnt = 0;
        for (int i = 0; i < n; i++)
            if (!gone[i] && batch_boxes[i].sc > score_lim) begin
                expected_kept = {expected_kept, as_kept(batch_boxes[i], 1'b0)};
                cnt++;
            end
        if (cnt == 0) begin
            k = '{default: '0};
            k.last = 1'b1;
            k.none = 1'b1;
            expected_kept = {expected_kept, k};
        end else begin
            expected_kept[expected_kept.size() - 1].last = 1'b1;
        end
        batch_boxes.delete();
    endtask

    // Predictor side of an accepted box; drops boxes beyond capacity.
    task automatic absorb_box(box_word_t b);
        if (batch_boxes.size() < MAX_BOXES) batch_boxes = {batch_boxes, b};
        if (b.last) predict_batch();
    endtask

    // Acceptance is decided from values sampled at the rising edge.
    logic took_word;
    always @(posedge clk) begin
        took_word <= rst_n && start && !busy;
        if (rst_n && start && !busy) begin
            absorb_box(pending_boxes.pop_front());
        end
    end

    // Driver: at each falling edge it offers the next pending box, or idles.
    always @(negedge clk) begin
        if (!rst_n || !drive_on) begin
            start <= 1'b0;
        end else if (start && !took_word) begin
            // The current word has not been taken yet; hold it.
        end else if (pending_boxes.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 4);
            start <= 1'b0;
        end else begin
            start    <= 1'b1;
            x_min    <= pending_boxes[0].x0;
            x_max    <= pending_boxes[0].x1;
            y_min    <= pending_boxes[0].y0;
            y_max    <= pending_boxes[0].y1;
            score    <= pending_boxes[0].sc;
            last_box <= pending_boxes[0].last;
        end
    end

    // Monitor: every result word is compared with the oldest expectation.
    always @(posedge clk) begin
        kept_word_t e;
        if (rst_n && result_valid) begin
            if (expected_kept.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                e = expected_kept.pop_front();
                if (out_x_min !== e.x0) begin
                    $error("out_x_min: expected %0d, got %0d", e.x0, out_x_min);
                    error_count++;
                end
                if (out_x_max !== e.x1) begin
                    $error("out_x_max: expected %0d, got %0d", e.x1, out_x_max);
                    error_count++;
                end
                if (out_y_min !== e.y0) begin
                    $error("out_y_min: expected %0d, got %0d", e.y0, out_y_min);
                    error_count++;
                end
                if (out_y_max !== e.y1) begin
                    $error("out_y_max: expected %0d, got %0d", e.y1, out_y_max);
                    error_count++;
                end
                if (out_score !== e.sc) begin
                    $error("out_score: expected %0d, got %0d", e.sc, out_score);
                    error_count++;
                end
                if (last_out !== e.last) begin
                    $error("last_out: expected %0d, got %0d", e.last, last_out);
                    error_count++;
                end
                if (none_kept !== e.none) begin
                    $error("none_kept: expected %0d, got %0d", e.none, none_kept);
                    error_count++;
                end
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic box_word_t make_box(int x0, int x1, int y0, int y1,
                                           int sc, bit last);
        box_word_t b;
        b.x0 = 12'(x0); b.x1 = 12'(x1); b.y0 = 12'(y0); b.y1 = 12'(y1);
        b.sc = 16'(sc); b.last = last;
        return b;
    endfunction

    // A random box near an anchor, so that boxes of one batch tend to overlap.
    function automatic box_word_t near_box(int cx, int cy, bit last);
        int w, h, x0, y0;
        w  = $urandom_range(0, 300);
        h  = $urandom_range(0, 300);
        x0 = cx + $urandom_range(0, 60);
        y0 = cy + $urandom_range(0, 60);
        return make_box(x0, (x0 + w > 4095) ? 4095 : x0 + w,
                        y0, (y0 + h > 4095) ? 4095 : y0 + h,
                        $urandom_range(0, 65535), last);
    endfunction

    function automatic box_word_t wild_box(bit last);
        return make_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 65535), last);
    endfunction

    // Queues one batch of n boxes; most are clustered, some fully random.
    task automatic queue_batch(int n);
        int cx, cy;
        cx = $urandom_range(0, 3700);
        cy = $urandom_range(0, 3700);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 4) == 0)
                pending_boxes = {pending_boxes, wild_box(i == n - 1)};
            else
                pending_boxes = {pending_boxes, near_box(cx, cy, i == n - 1)};
    endtask

    // Waits until the driver has handed over every box and all results came,
    // then lets the block finish any trailing work.
    task automatic drain();
        while (pending_boxes.size() != 0 || expected_kept.size() != 0 || start)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Register write on the APB port: setup cycle, then access cycle.
    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr[2] == REG_OVERLAP) overlap_lim = value;
        else                        score_lim   = value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // The block is drained first, so no word is in flight during the writes.
    task automatic set_limits(logic [15:0] ov, logic [15:0] sc);
        drain();
        drive_on = 1'b0;
        reg_write({REG_OVERLAP, 2'b00}, ov);
        reg_write({REG_SCORE, 2'b00}, sc);
        drive_on = 1'b1;
    endtask

    initial begin
        logic [15:0] ov_set[4];
        logic [15:0] sc_set[4];
        rst_n = 1'b0;
        start = 1'b0;
        x_min = '0; x_max = '0; y_min = '0; y_max = '0;
        score = '0; last_box = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        took_word = 1'b0;
        drive_on = 1'b0; quiet_tail = 1'b0; gap_left = 0;
        error_count = 0; cycle_count = 0;
        overlap_lim = OVERLAP_RESET;
        score_lim   = SCORE_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        drive_on = 1'b1;

        // Directed part at reset limits: single box with a low score passes
        // unchanged, corner values, a full overlap, equal scores, degenerate
        // boxes and a batch where nothing is kept.
        pending_boxes = {pending_boxes, make_box(0, 0, 0, 0, 0, 1)};
        pending_boxes = {pending_boxes, make_box(4095, 4095, 4095, 4095, 65535, 1)};
        pending_boxes = {pending_boxes, make_box(0, 4095, 0, 4095, 65535, 0)};
        pending_boxes = {pending_boxes, make_box(0, 4095, 0, 4095, 60000, 1)};
        pending_boxes = {pending_boxes, make_box(10, 100, 10, 100, 50000, 0)};
        pending_boxes = {pending_boxes, make_box(10, 100, 10, 100, 50000, 0)};
        pending_boxes = {pending_boxes, make_box(200, 100, 5, 50, 65000, 1)};
        pending_boxes = {pending_boxes, make_box(1, 2, 1, 2, 100, 0)};
        pending_boxes = {pending_boxes, make_box(3, 9, 3, 9, 32768, 1)};
        pending_boxes = {pending_boxes, make_box(0, 50, 0, 50, 40000, 0)};
        pending_boxes = {pending_boxes, make_box(40, 90, 40, 90, 45000, 0)};
        pending_boxes = {pending_boxes, make_box(2730, 1365, 1365, 2730, 43690, 1)};

        // Pause until the block has answered everything so far.
        drain();

        // Overfull batch: capacity plus a few, mark on a dropped box.
        for (int i = 0; i < MAX_BOXES + 3; i++)
            pending_boxes = {pending_boxes, wild_box(i == MAX_BOXES + 2)};
        drain();

        ov_set = '{16'd0, 16'd65535, 16'd32768, 16'd45875};
        sc_set = '{16'd65535, 16'd0, 16'd20000, 16'd32768};
        for (int p = 0; p < 4; p++) begin
            set_limits(ov_set[p], sc_set[p]);
            for (int b = 0; b < 12; b++) queue_batch($urandom_range(1, 12));
            if (p == 3) quiet_tail = 1'b1;
        end
        // Quiet tail: a few more batches with no idling.
        for (int b = 0; b < 6; b++) queue_batch($urandom_range(1, 8));

        drain();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
